>>> rtl/core/rtvd_pkg.sv
// Shared constants and types of the 2D total-variation denoiser.
// Used by rtvd_nlu and rof_tv_denoise_2d; depends on nothing.
package rtvd_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;

  // eps = 1.0e-4 in Q.32
  localparam logic [49:0] EPS_Q32 = 50'd429497;
  localparam logic [14:0] GRAD_MAX = 15'h7fff;

  typedef enum logic [2:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_ITER   = 3'd2,
    CFG_STEP   = 3'd3,
    CFG_LAMBDA = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        start;
    logic [15:0] ud;
    logic [15:0] um;
  } nlu_req_t;

  typedef struct packed {
    logic        done;
    logic [14:0] mag;
  } nlu_rsp_t;

endpackage

>>> rtl/core/rtvd_nlu.sv
// Normalised gradient unit: |d| * 2^22 / isqrt((d^2 + m^2) * 2^16 + eps).
// One shared multiplier, bit-serial root and restoring divide. Uses rtvd_pkg.
module rtvd_nlu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rtvd_pkg::nlu_req_t req_i,
  output rtvd_pkg::nlu_rsp_t rsp_o
);
  import rtvd_pkg::*;

  typedef enum logic [2:0] {
    N_IDLE, N_SQ1, N_SQ2, N_SUM, N_ROOT, N_DIVI, N_DIV, N_DONE
  } nst_e;

  nst_e        st_q;
  logic [15:0] ud_q, um_q, mul_a;
  logic [31:0] prod_q;
  logic [32:0] acc_q, acc_sum;
  logic [49:0] x_q, res_q, bit_q, trial;
  logic [41:0] num_q, den_q;
  logic [16:0] quo_q;
  logic [4:0]  cnt_q;

  assign mul_a   = (st_q == N_SQ1) ? ud_q : um_q;
  assign acc_sum = acc_q + {1'b0, prod_q};
  assign trial   = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= N_IDLE;
      ud_q   <= '0;
      um_q   <= '0;
      prod_q <= '0;
      acc_q  <= '0;
      x_q    <= '0;
      res_q  <= '0;
      bit_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
    end else begin
      case (st_q)
        N_IDLE: begin
          if (req_i.start) begin
            ud_q <= req_i.ud;
            um_q <= req_i.um;
            st_q <= N_SQ1;
          end
        end
        N_SQ1: begin
          prod_q <= mul_a * mul_a;
          st_q   <= N_SQ2;
        end
        N_SQ2: begin
          acc_q  <= {1'b0, prod_q};
          prod_q <= mul_a * mul_a;
          st_q   <= N_SUM;
        end
        N_SUM: begin
          x_q   <= {1'b0, acc_sum, 16'b0} + EPS_Q32;
          res_q <= '0;
          bit_q <= 50'd1 << 48;
          st_q  <= N_ROOT;
        end
        N_ROOT: begin
          if (x_q >= trial) begin
            x_q   <= x_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) st_q <= N_DIVI;
        end
        N_DIVI: begin
          num_q <= {4'b0, ud_q, 22'b0} + {17'b0, res_q[25:1]};
          den_q <= {res_q[25:0], 16'b0};
          quo_q <= '0;
          cnt_q <= 5'd16;
          st_q  <= N_DIV;
        end
        N_DIV: begin
          if (num_q >= den_q) begin
            num_q <= num_q - den_q;
            quo_q <= {quo_q[15:0], 1'b1};
          end else begin
            quo_q <= {quo_q[15:0], 1'b0};
          end
          den_q <= den_q >> 1;
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) st_q <= N_DONE;
        end
        N_DONE: st_q <= N_IDLE;
        default: st_q <= N_IDLE;
      endcase
    end
  end

  assign rsp_o.done = (st_q == N_DONE);
  assign rsp_o.mag  = (quo_q > {2'b0, GRAD_MAX}) ? GRAD_MAX : quo_q[14:0];

endmodule

>>> rtl/core/rof_tv_denoise_2d.sv
// A request's result passes state S_OUT and then the output register; one request at a time,
// so no new request is taken until a ready sink has taken the pending result.
// A frame-ending request then busies the block with a copy of the frame plus
// iterations of a gradient pass, through the shared gradient unit, and an update pass.
// Reset: async active low; position and result flag clear, frame stores stay unset.
// Depends on rtvd_pkg and rtvd_nlu.
module rof_tv_denoise_2d (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] pixel_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] pixel_out
  output logic        m_axis_tuser,   // [0] result_valid
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import rtvd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_OUT, S_CRD, S_CWR, S_GRD, S_GN1, S_GW1, S_GN2, S_GW2,
    S_URD, S_UM1, S_UM2, S_UM3, S_UWR
  } st_e;

  function automatic logic [XW:0] clamp_w(input logic [8:0] v);
    int t;
    t = int'(v);
    if (t < 2) return (XW+1)'(2);
    if (t > MAX_WIDTH) return (XW+1)'(MAX_WIDTH);
    return (XW+1)'(t);
  endfunction

  function automatic logic [YW:0] clamp_h(input logic [8:0] v);
    int t;
    t = int'(v);
    if (t < 2) return (YW+1)'(2);
    if (t > MAX_HEIGHT) return (YW+1)'(MAX_HEIGHT);
    return (YW+1)'(t);
  endfunction

  function automatic logic signed [16:0] minmod(input logic signed [16:0] a,
                                                input logic signed [16:0] b);
    if (a > 0 && b > 0) return (a < b) ? a : b;
    if (a < 0 && b < 0) return (a > b) ? a : b;
    return '0;
  endfunction

  function automatic logic [15:0] mag17(input logic signed [16:0] a);
    logic signed [16:0] n;
    n = -a;
    return a[16] ? n[15:0] : a[15:0];
  endfunction

  // configuration
  logic [8:0]  cfg_w_q, cfg_h_q;
  logic [9:0]  cfg_it_q;
  logic [15:0] cfg_tau_q, cfg_lam_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= 9'd256;
      cfg_h_q   <= 9'd256;
      cfg_it_q  <= '0;
      cfg_tau_q <= 16'd4096;
      cfg_lam_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  cfg_w_q   <= cfg_data_i[8:0];
        CFG_HEIGHT: cfg_h_q   <= cfg_data_i[8:0];
        CFG_ITER:   cfg_it_q  <= cfg_data_i[9:0];
        CFG_STEP:   cfg_tau_q <= cfg_data_i;
        CFG_LAMBDA: cfg_lam_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [XW:0] w;
  logic [YW:0] h;
  logic [AW:0] total;
  assign w     = clamp_w(cfg_w_q);
  assign h     = clamp_h(cfg_h_q);
  assign total = (AW+1)'(w * h);

  // sequencer state
  st_e         st_q;
  logic [AW-1:0] pos_q, rb_q;
  logic        have_q, lastp_q;
  logic [XW-1:0] i_q;
  logic [YW-1:0] j_q;
  logic [2:0]  k_q;
  logic [9:0]  it_q;
  logic [15:0] v_q [0:4];
  logic [15:0] rg_q, r0_q, c0_q, u_q, f_q, r1_q, c1_q;
  logic signed [17:0] div_q;
  logic signed [33:0] m1_q;
  logic signed [34:0] inner_q;
  logic signed [51:0] m2_q;
  logic        m_valid_q, m_user_q, m_last_q;
  logic [15:0] m_data_q;

  // addressing
  logic [XW:0]   i_plus, in_col, ip_col;
  logic [AW-1:0] p_addr, rb_n, rb_p, a_dn, a_up, a_rt, a_lt;
  logic          last_col, last_row, accept, in_last;

  assign i_plus   = {1'b0, i_q} + (XW+1)'(1);
  assign in_col   = (i_plus < w) ? i_plus : {1'b0, i_q} - (XW+1)'(1);
  assign ip_col   = (i_q != '0) ? {1'b0, i_q} - (XW+1)'(1) : i_plus;
  assign last_col = (i_plus == w);
  assign last_row = (({1'b0, j_q} + (YW+1)'(1)) == h);
  assign rb_n     = last_row ? rb_q - AW'(w) : rb_q + AW'(w);
  assign rb_p     = (j_q != '0) ? rb_q - AW'(w) : rb_q + AW'(w);
  assign p_addr   = rb_q + AW'(i_q);
  assign a_dn     = rb_n + AW'(i_q);
  assign a_up     = rb_p + AW'(i_q);
  assign a_rt     = rb_q + AW'(in_col[XW-1:0]);
  assign a_lt     = rb_q + AW'(ip_col[XW-1:0]);

  assign s_axis_tready = (st_q == S_IDLE) && !m_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_last       = (({1'b0, pos_q} + (AW+1)'(1)) >= total);

  // frame stores
  logic [15:0] noisy_mem [2**AW];
  logic [15:0] work_mem  [2**AW];
  logic [15:0] rowg_mem  [2**AW];
  logic [15:0] colg_mem  [2**AW];
  logic [AW-1:0] noisy_wa, noisy_ra, work_wa, work_ra, grad_ra_r, grad_ra_c;
  logic [15:0]   noisy_rd, work_rd, rowg_rd, colg_rd, work_wd, grad_wd;
  logic          work_we, grad_we;

  assign noisy_wa = pos_q;
  assign noisy_ra = p_addr;
  assign work_wa  = p_addr;

  always_comb begin
    case (st_q)
      S_IDLE:  work_ra = pos_q;
      S_GRD: begin
        case (k_q)
          3'd0:    work_ra = p_addr;
          3'd1:    work_ra = a_dn;
          3'd2:    work_ra = a_up;
          3'd3:    work_ra = a_rt;
          default: work_ra = a_lt;
        endcase
      end
      default: work_ra = p_addr;
    endcase
  end

  assign grad_ra_r = (k_q == 3'd0) ? p_addr : a_up;
  assign grad_ra_c = (k_q == 3'd0) ? p_addr : a_lt;

  always_ff @(posedge clk_i) begin
    if (accept) noisy_mem[noisy_wa] <= s_axis_tdata;
    noisy_rd <= noisy_mem[noisy_ra];
  end

  always_ff @(posedge clk_i) begin
    if (work_we) work_mem[work_wa] <= work_wd;
    work_rd <= work_mem[work_ra];
  end

  always_ff @(posedge clk_i) begin
    if (grad_we) rowg_mem[p_addr] <= rg_q;
    rowg_rd <= rowg_mem[grad_ra_r];
  end

  always_ff @(posedge clk_i) begin
    if (grad_we) colg_mem[p_addr] <= grad_wd;
    colg_rd <= colg_mem[grad_ra_c];
  end

  // gradient datapath
  logic signed [16:0] a_s, dv, dvb, dh, dhb;
  nlu_req_t nreq;
  nlu_rsp_t nrsp;
  logic     gneg;
  logic [15:0] gval;

  assign a_s = {v_q[0][15], v_q[0]};
  assign dv  = {v_q[1][15], v_q[1]} - a_s;
  assign dvb = a_s - {v_q[2][15], v_q[2]};
  assign dh  = {v_q[3][15], v_q[3]} - a_s;
  assign dhb = a_s - {v_q[4][15], v_q[4]};

  assign nreq.start = (st_q == S_GN1) || (st_q == S_GN2);
  assign nreq.ud    = (st_q == S_GN1) ? mag17(dv) : mag17(dh);
  assign nreq.um    = (st_q == S_GN1) ? mag17(minmod(dh, dhb)) : mag17(minmod(dv, dvb));

  rtvd_nlu u_nlu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (nreq),
    .rsp_o  (nrsp)
  );

  assign gneg    = (st_q == S_GW1) ? dv[16] : dh[16];
  assign gval    = gneg ? 16'(-{1'b0, nrsp.mag}) : {1'b0, nrsp.mag};
  assign grad_we = (st_q == S_GW2) && nrsp.done;
  assign grad_wd = gval;

  // update datapath
  logic signed [51:0] rnd;
  logic signed [27:0] delta;
  logic signed [28:0] usum;
  logic [15:0]        unew;

  assign rnd   = m2_q + 52'sd8388608;
  assign delta = 28'(rnd >>> 24);
  assign usum  = {{13{u_q[15]}}, u_q} + {delta[27], delta};
  always_comb begin
    if (usum > 29'sd32767)       unew = 16'h7fff;
    else if (usum < -29'sd32768) unew = 16'h8000;
    else                         unew = usum[15:0];
  end

  assign work_we = (st_q == S_CWR) || (st_q == S_UWR);
  assign work_wd = (st_q == S_CWR) ? noisy_rd : unew;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      pos_q     <= '0;
      have_q    <= 1'b0;
      lastp_q   <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      rb_q      <= '0;
      k_q       <= '0;
      it_q      <= '0;
      for (int n = 0; n < 5; n++) v_q[n] <= '0;
      rg_q      <= '0;
      r0_q      <= '0;
      c0_q      <= '0;
      u_q       <= '0;
      f_q       <= '0;
      r1_q      <= '0;
      c1_q      <= '0;
      div_q     <= '0;
      m1_q      <= '0;
      inner_q   <= '0;
      m2_q      <= '0;
      m_valid_q <= 1'b0;
      m_user_q  <= 1'b0;
      m_last_q  <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (accept) begin
            lastp_q <= in_last;
            pos_q   <= in_last ? '0 : pos_q + AW'(1);
            st_q    <= S_OUT;
          end
        end
        S_OUT: begin
          m_data_q  <= have_q ? work_rd : '0;
          m_user_q  <= have_q;
          m_last_q  <= lastp_q;
          m_valid_q <= 1'b1;
          i_q       <= '0;
          j_q       <= '0;
          rb_q      <= '0;
          it_q      <= '0;
          st_q      <= lastp_q ? S_CRD : S_IDLE;
        end
        S_CRD: st_q <= S_CWR;
        S_CWR: begin
          if (last_col) begin
            i_q <= '0;
            if (last_row) begin
              j_q  <= '0;
              rb_q <= '0;
              k_q  <= '0;
              if (cfg_it_q == '0) begin
                have_q <= 1'b1;
                st_q   <= S_IDLE;
              end else begin
                st_q <= S_GRD;
              end
            end else begin
              j_q  <= j_q + YW'(1);
              rb_q <= rb_q + AW'(w);
              st_q <= S_CRD;
            end
          end else begin
            i_q  <= i_q + XW'(1);
            st_q <= S_CRD;
          end
        end
        S_GRD: begin
          if (k_q != 3'd0) v_q[k_q - 3'd1] <= work_rd;
          if (k_q == 3'd5) begin
            k_q  <= '0;
            st_q <= S_GN1;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        S_GN1: st_q <= S_GW1;
        S_GW1: begin
          if (nrsp.done) begin
            rg_q <= gval;
            st_q <= S_GN2;
          end
        end
        S_GN2: st_q <= S_GW2;
        S_GW2: begin
          if (nrsp.done) begin
            if (last_col) begin
              i_q <= '0;
              if (last_row) begin
                j_q  <= '0;
                rb_q <= '0;
                st_q <= S_URD;
              end else begin
                j_q  <= j_q + YW'(1);
                rb_q <= rb_q + AW'(w);
                st_q <= S_GRD;
              end
            end else begin
              i_q  <= i_q + XW'(1);
              st_q <= S_GRD;
            end
          end
        end
        S_URD: begin
          if (k_q == 3'd1) begin
            r0_q <= rowg_rd;
            c0_q <= colg_rd;
            u_q  <= work_rd;
            f_q  <= noisy_rd;
          end
          if (k_q == 3'd2) begin
            r1_q <= rowg_rd;
            c1_q <= colg_rd;
            k_q  <= '0;
            st_q <= S_UM1;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        S_UM1: begin
          div_q <= {{2{r0_q[15]}}, r0_q} - {{2{r1_q[15]}}, r1_q}
                 + {{2{c0_q[15]}}, c0_q} - {{2{c1_q[15]}}, c1_q};
          m1_q  <= $signed({1'b0, cfg_lam_q})
                 * ($signed({u_q[15], u_q}) - $signed({f_q[15], f_q}));
          st_q  <= S_UM2;
        end
        S_UM2: begin
          inner_q <= $signed({{11{div_q[17]}}, div_q, 6'b0})
                   - $signed({m1_q[33], m1_q});
          st_q    <= S_UM3;
        end
        S_UM3: begin
          m2_q <= inner_q * $signed({1'b0, cfg_tau_q});
          st_q <= S_UWR;
        end
        S_UWR: begin
          if (last_col) begin
            i_q <= '0;
            if (last_row) begin
              j_q  <= '0;
              rb_q <= '0;
              if (it_q + 10'd1 == cfg_it_q) begin
                have_q <= 1'b1;
                st_q   <= S_IDLE;
              end else begin
                it_q <= it_q + 10'd1;
                st_q <= S_GRD;
              end
            end else begin
              j_q  <= j_q + YW'(1);
              rb_q <= rb_q + AW'(w);
              st_q <= S_URD;
            end
          end else begin
            i_q  <= i_q + XW'(1);
            st_q <= S_URD;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule

>>> rtl/core/rtvd_checker.sv
// Port-level checks for rof_tv_denoise_2d, attached by bind.
// Depends only on the top level's ports.
module rtvd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("ready while a result is pending");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("pixel without result not zero");

endmodule

bind rof_tv_denoise_2d rtvd_checker u_rtvd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
